>>> rtl/core/midi_channel_message_parser_top_macros.svh
// Assertion macros for the MIDI channel message parser.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_TOP_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same clock edge.
`define MCMP_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mcmp_pkg.sv
// Shared types, constants and functions of the MIDI channel message parser.
package mcmp_pkg;

    typedef enum logic [1:0] {
        MSG_NOTE_OFF = 2'd0,
        MSG_NOTE_ON  = 2'd1,
        MSG_CTRL     = 2'd2,
        MSG_PITCH    = 2'd3
    } t_msg_type;

    typedef enum logic [1:0] {
        EV_NOTE    = 2'd0,
        EV_ALL_OFF = 2'd1,
        EV_CTRL    = 2'd2,
        EV_PITCH   = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_req;

    localparam logic [1:0] POS_STATUS = 2'd0;
    localparam logic [1:0] POS_DATA1  = 2'd1;
    localparam logic [1:0] POS_DATA2  = 2'd2;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PITCH    = 4'hE;

    localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;
    localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

    localparam logic [15:0] PITCH_MAX    = 16'h4000;
    localparam logic [7:0]  PITCH_TOP    = 8'd128;
    localparam logic [4:0]  DRUM_CHANNEL = 5'd10;
    localparam logic [2:0]  VOICE_DRUM   = 3'd4;
    localparam logic [2:0]  VOICE_NONE   = 3'd5;

    function automatic logic [2:0] voice_of(input logic [4:0] chan);
        logic [4:0] idx;
        idx = chan - 5'd1;
        if (chan >= 5'd1 && chan <= 5'd4) begin
            return idx[2:0];
        end else if (chan == DRUM_CHANNEL) begin
            return VOICE_DRUM;
        end else begin
            return VOICE_NONE;
        end
    endfunction

endpackage

>>> rtl/core/mcmp_in_reg.sv
// Input register stage that holds one received byte until the parser takes it.
module mcmp_in_reg
    import mcmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic      i_advance,
    output t_byte_req o_req
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_req.valid   = r_valid;
    assign o_req.rx_byte = r_byte;

endmodule

>>> rtl/core/mcmp_decode.sv
// Message state, event decode and result register.
module mcmp_decode
    import mcmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_byte_req   i_req,
    output logic        o_advance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_event_kind o_event_kind,
    output logic [2:0]  o_voice_target,
    output logic [4:0]  o_midi_channel,
    output logic [7:0]  o_key_or_controller,
    output logic [7:0]  o_event_value
);

    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    t_msg_type   r_type;
    t_msg_type   n_type;
    logic [3:0]  r_chan;
    logic [3:0]  n_chan;
    logic [7:0]  r_data1;
    logic [7:0]  n_data1;
    logic        r_out_valid;
    logic        n_out_valid;
    t_event_kind r_kind;
    t_event_kind n_kind;
    logic [2:0]  r_voice;
    logic [7:0]  r_key;
    logic [7:0]  n_key;
    logic [7:0]  r_value;
    logic [7:0]  n_value;
    logic [4:0]  r_midi_chan;
    logic [4:0]  chan;
    logic        emit;
    logic        out_taken;
    logic [15:0] pitch_sum;
    logic [15:0] pitch_clamp;
    logic [7:0]  b;

    assign b         = i_req.rx_byte;
    assign out_taken = r_out_valid && !i_out_stall;
    assign o_advance = i_req.valid && (!r_out_valid || !i_out_stall);
    assign chan      = {1'b0, r_chan} + 5'd1;

    assign pitch_sum   = {1'b0, b, 7'd0} + {8'd0, r_data1};
    assign pitch_clamp = (pitch_sum > PITCH_MAX) ? PITCH_MAX : pitch_sum;

    always_comb begin
        n_pos   = r_pos;
        n_type  = r_type;
        n_chan  = r_chan;
        n_data1 = r_data1;
        emit    = 1'b0;
        n_kind  = EV_NOTE;
        n_key   = r_data1;
        n_value = b;
        unique case (r_pos)
            POS_STATUS: begin
                n_pos  = POS_DATA1;
                n_chan = b[3:0];
                unique case (b[7:4])
                    ST_NOTE_OFF: n_type = MSG_NOTE_OFF;
                    ST_NOTE_ON:  n_type = MSG_NOTE_ON;
                    ST_CTRL:     n_type = MSG_CTRL;
                    ST_PITCH:    n_type = MSG_PITCH;
                    default: begin
                        // drop unsupported status, stay at message start
                        n_pos  = POS_STATUS;
                        n_chan = r_chan;
                    end
                endcase
            end
            POS_DATA1: begin
                n_data1 = b;
                n_pos   = POS_DATA2;
            end
            default: begin
                n_pos = POS_STATUS;
                emit  = 1'b1;
                unique case (r_type)
                    MSG_NOTE_OFF: begin
                        n_kind  = EV_NOTE;
                        n_value = 8'd0;
                    end
                    MSG_NOTE_ON: begin
                        n_kind = EV_NOTE;
                    end
                    MSG_CTRL: begin
                        if (r_data1 == CC_ALL_SOUND_OFF || r_data1 == CC_ALL_NOTES_OFF) begin
                            n_kind  = EV_ALL_OFF;
                            n_key   = 8'd0;
                            n_value = 8'd0;
                        end else begin
                            n_kind = EV_CTRL;
                        end
                    end
                    default: begin
                        n_kind  = EV_PITCH;
                        n_key   = 8'd0;
                        n_value = pitch_clamp[14:7];
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        if (o_advance) begin
            n_out_valid = emit;
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_STATUS;
            r_type      <= MSG_NOTE_OFF;
            r_chan      <= 4'd0;
            r_data1     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_advance) begin
                r_pos   <= n_pos;
                r_type  <= n_type;
                r_chan  <= n_chan;
                r_data1 <= n_data1;
            end
        end
        if (o_advance && emit) begin
            r_kind      <= n_kind;
            r_voice     <= voice_of(chan);
            r_midi_chan <= chan;
            r_key       <= n_key;
            r_value     <= n_value;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_kind        = r_kind;
    assign o_voice_target      = r_voice;
    assign o_midi_channel      = r_midi_chan;
    assign o_key_or_controller = r_key;
    assign o_event_value       = r_value;

endmodule

>>> rtl/core/midi_channel_message_parser_top.sv
// MIDI channel message parser: one received byte in per request, one event per message out.
// Takes one byte per clock cycle with no gaps while the event side keeps up. A byte passes
// an input register and then the decode logic into the result register. Note-off, note-on,
// control change and pitch bend are recognized; the two bytes after a recognized status byte
// are data whatever their value.
module midi_channel_message_parser_top
    import mcmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_event_kind,
    output logic [2:0] o_voice_target,
    output logic [4:0] o_midi_channel,
    output logic [7:0] o_key_or_controller,
    output logic [7:0] o_event_value
);

`include "midi_channel_message_parser_top_macros.svh"

    t_byte_req   s_req;
    logic        s_advance;
    t_event_kind s_kind;

    mcmp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_rx_byte (i_rx_byte),
        .i_advance (s_advance),
        .o_req     (s_req)
    );

    mcmp_decode u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req               (s_req),
        .o_advance           (s_advance),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_event_kind        (s_kind),
        .o_voice_target      (o_voice_target),
        .o_midi_channel      (o_midi_channel),
        .o_key_or_controller (o_key_or_controller),
        .o_event_value       (o_event_value)
    );

    assign o_event_kind = s_kind;

    `MCMP_ASSERT(a_new_event_from_byte, $rose(o_out_valid) |-> $past(s_req.valid), "event without a byte")
    `MCMP_ASSERT_IMPL(a_pitch_range, o_out_valid && s_kind == EV_PITCH, o_key_or_controller == 8'd0 && o_event_value <= PITCH_TOP, "pitch event out of range")
    `MCMP_ASSERT_IMPL(a_drum_voice, o_out_valid && o_voice_target == VOICE_DRUM, o_midi_channel == DRUM_CHANNEL, "drum voice on wrong channel")
    `MCMP_ASSERT_IMPL(a_all_off_zero, o_out_valid && s_kind == EV_ALL_OFF, o_key_or_controller == 8'd0 && o_event_value == 8'd0, "all-off event carries data")

endmodule
